### hw/rtl/ptr_pkg.sv
// Package for the page table replacement block: sizes, policy codes, FSM states
// and the struct passed between the controller and the entry cells.
// No dependencies.
package ptr_pkg;
  localparam int ENTRIES  = 16;
  localparam int IDX_W    = $clog2(ENTRIES);
  localparam int CNT_W    = $clog2(ENTRIES + 1);
  localparam int PAGE_W   = 40;
  localparam int PROC_W   = 16;
  localparam int TIME_W   = 32;
  localparam int SLOT_W   = 4;
  localparam int IN_W     = 88;
  localparam int OUT_W    = 96;

  typedef enum logic [1:0] {
    POL_LRU   = 2'd0,
    POL_FIFO  = 2'd1,
    POL_CLOCK = 2'd2,
    POL_ZERO  = 2'd3
  } policy_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MATCH,
    ST_SCAN,
    ST_WRITE,
    ST_OUT
  } state_t;

  // Data each chain stage (ptr_stage) hands to the next one during a scan.
  typedef struct packed {
    logic              found;
    logic [TIME_W-1:0] best;
    logic [IDX_W-1:0]  idx;
  } scan_t;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    logic              install;
    logic              touch;
    logic              clr_mark;
    logic [IDX_W-1:0]  sel;
    logic [PAGE_W-1:0] page;
    logic [PROC_W-1:0] proc;
    logic [TIME_W-1:0] now;
  } cmd_t;

  // Contents one cell reports.
  typedef struct packed {
    logic              valid;
    logic              mark;
    logic              match;
    logic [PAGE_W-1:0] page;
    logic [PROC_W-1:0] proc;
    logic [TIME_W-1:0] itime;
    logic [TIME_W-1:0] atime;
  } cell_t;
endpackage

### hw/rtl/page_table_replacement.sv
// Top level of the page table replacement block: APB registers, controller,
// row of entry cells and registered min chain. Depends on ptr_pkg, ptr_cell, ptr_stage.
// A hit, an empty fill or a slot-zero eviction goes from match straight to write; LRU/FIFO
// eviction waits in the scan state for the min chain, clock eviction steps the hand in scan.
// One access in flight; the next beat is taken once its result is registered, which waits
// while an untaken result still holds the output register.
// Reset is synchronous active low and clears all entries, the counters, state and out_tvalid.
module page_table_replacement import ptr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // page_number [39:0], process_id [55:40], now [87:56]
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // hit [0], slot [4:1], evicted_valid [5], evicted_page [45:6],
  // evicted_process [61:46], miss_total [93:62], zero [95:94]
  output logic [OUT_W-1:0] out_tdata,
  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic [2:0]       cfg_paddr,
  input  logic [31:0]      cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  localparam logic [2:0] ADDR_POLICY = 3'd0;
  localparam logic [2:0] ADDR_TAU    = 3'd4;

  policy_t           policy_r;
  logic [TIME_W-1:0] tau_r;
  logic              wr;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= POL_LRU;
      tau_r    <= 32'd1000;
    end else if (wr) begin
      if (cfg_paddr == ADDR_POLICY) policy_r <= policy_t'(cfg_pwdata[1:0]);
      else if (cfg_paddr == ADDR_TAU) tau_r <= cfg_pwdata;
    end
  end

  always_comb begin
    case (cfg_paddr)
      ADDR_POLICY: cfg_prdata = {30'd0, policy_r};
      ADDR_TAU:    cfg_prdata = tau_r;
      default:     cfg_prdata = '0;
    endcase
  end

  state_t             state_r, state_nxt;
  logic [PAGE_W-1:0]  page_r;
  logic [PROC_W-1:0]  proc_r;
  logic [TIME_W-1:0]  now_r;
  logic               hit_r, hit_nxt;
  logic [IDX_W-1:0]   slot_r, slot_nxt;
  logic [IDX_W-1:0]   hand_r, hand_nxt;
  logic [CNT_W-1:0]   filled_r, filled_nxt;
  logic [TIME_W-1:0]  miss_r, miss_nxt;
  logic [IDX_W:0]     step_r, step_nxt;
  logic [IDX_W:0]     cnt_r, cnt_nxt;
  logic               evv_r, evv_nxt;
  logic [PAGE_W-1:0]  evp_r, evp_nxt;
  logic [PROC_W-1:0]  evq_r, evq_nxt;
  logic               ov_r, ov_nxt;
  logic [OUT_W-1:0]   out_r;
  cmd_t               cmd;
  cell_t              info [ENTRIES];
  scan_t              chain [ENTRIES+1];
  logic               any_hit, any_empty;
  logic [IDX_W-1:0]   hit_idx, empty_idx;
  logic [TIME_W-1:0]  age;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_row
    ptr_cell u_cell (
      .clk(clk), .rst_n(rst_n), .my_idx(IDX_W'(g)), .cmd(cmd), .info(info[g])
    );
    ptr_stage u_stage (
      .clk(clk), .my_idx(IDX_W'(g)),
      .t(policy_r == POL_FIFO ? info[g].itime : info[g].atime),
      .din(chain[g]), .dout(chain[g+1])
    );
  end

  assign chain[0] = '{found: 1'b0, best: now_r, idx: '0};

  always_comb begin
    any_hit = 1'b0;
    hit_idx = '0;
    any_empty = 1'b0;
    empty_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (info[i].match) begin
        any_hit = 1'b1;
        hit_idx = IDX_W'(i);
      end
      if (!info[i].valid) begin
        any_empty = 1'b1;
        empty_idx = IDX_W'(i);
      end
    end
  end

  assign age = now_r - info[hand_r].atime;
  assign in_tready = (state_r == ST_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      hand_r   <= '0;
      filled_r <= '0;
      miss_r   <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      hand_r   <= hand_nxt;
      filled_r <= filled_nxt;
      miss_r   <= miss_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      page_r <= in_tdata[PAGE_W-1:0];
      proc_r <= in_tdata[PAGE_W+PROC_W-1:PAGE_W];
      now_r  <= in_tdata[IN_W-1:PAGE_W+PROC_W];
    end
    if (state_r == ST_OUT && (!ov_r || out_tready)) begin
      out_r <= {2'b00, miss_r, evq_r, evp_r, evv_r, SLOT_W'(slot_r), hit_r};
    end
    hit_r  <= hit_nxt;
    slot_r <= slot_nxt;
    step_r <= step_nxt;
    cnt_r  <= cnt_nxt;
    evv_r  <= evv_nxt;
    evp_r  <= evp_nxt;
    evq_r  <= evq_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    hand_nxt   = hand_r;
    filled_nxt = filled_r;
    miss_nxt   = miss_r;
    ov_nxt     = ov_r && !out_tready;
    hit_nxt    = hit_r;
    slot_nxt   = slot_r;
    step_nxt   = step_r;
    cnt_nxt    = cnt_r;
    evv_nxt    = evv_r;
    evp_nxt    = evp_r;
    evq_nxt    = evq_r;
    cmd.install  = 1'b0;
    cmd.touch    = 1'b0;
    cmd.clr_mark = 1'b0;
    cmd.sel      = slot_r;
    cmd.page     = page_r;
    cmd.proc     = proc_r;
    cmd.now      = now_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_MATCH;
      end
      ST_MATCH: begin
        evv_nxt = 1'b0;
        evp_nxt = '0;
        evq_nxt = '0;
        hit_nxt = any_hit;
        step_nxt = '0;
        cnt_nxt = '0;
        if (any_hit) begin
          slot_nxt = hit_idx;
          state_nxt = ST_WRITE;
        end else begin
          if (miss_r != '1) miss_nxt = miss_r + 32'd1;
          if (filled_r < CNT_W'(ENTRIES) && any_empty) begin
            slot_nxt = empty_idx;
            filled_nxt = filled_r + CNT_W'(1);
            state_nxt = ST_WRITE;
          end else if (policy_r == POL_ZERO) begin
            slot_nxt = '0;
            state_nxt = ST_WRITE;
            evv_nxt = 1'b1;
            evp_nxt = info[0].page;
            evq_nxt = info[0].proc;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (policy_r == POL_CLOCK) begin
          if (age >= tau_r && !info[hand_r].mark) begin
            slot_nxt = hand_r;
            state_nxt = ST_WRITE;
            evv_nxt = 1'b1;
            evp_nxt = info[hand_r].page;
            evq_nxt = info[hand_r].proc;
          end else if (step_r == (IDX_W+1)'(2 * ENTRIES - 1)) begin
            if (age >= tau_r) begin
              cmd.sel = hand_r;
              cmd.clr_mark = 1'b1;
            end
            slot_nxt = hand_r + IDX_W'(1);
            hand_nxt = hand_r + IDX_W'(1);
            state_nxt = ST_WRITE;
            evv_nxt = 1'b1;
            evp_nxt = info[hand_r + IDX_W'(1)].page;
            evq_nxt = info[hand_r + IDX_W'(1)].proc;
          end else begin
            if (age >= tau_r) begin
              cmd.sel = hand_r;
              cmd.clr_mark = 1'b1;
            end
            hand_nxt = hand_r + IDX_W'(1);
            step_nxt = step_r + (IDX_W+1)'(1);
          end
        end else begin
          cnt_nxt = cnt_r + (IDX_W+1)'(1);
          if (cnt_r == (IDX_W+1)'(ENTRIES)) begin
            slot_nxt = chain[ENTRIES].idx;
            state_nxt = ST_WRITE;
            evv_nxt = 1'b1;
            evp_nxt = info[chain[ENTRIES].idx].page;
            evq_nxt = info[chain[ENTRIES].idx].proc;
          end
        end
      end
      ST_WRITE: begin
        cmd.install = !hit_r;
        cmd.touch = hit_r;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!ov_r || out_tready) begin
          ov_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

### hw/rtl/ptr_cell.sv
// One entry of the page table: stores page, process, times and marks, and
// compares against the access. Depends on ptr_pkg.
module ptr_cell import ptr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] my_idx,
  input  cmd_t             cmd,
  output cell_t            info
);
  logic              valid_r, mark_r;
  logic [PAGE_W-1:0] page_r;
  logic [PROC_W-1:0] proc_r;
  logic [TIME_W-1:0] itime_r, atime_r;
  logic              sel;

  assign sel = (cmd.sel == my_idx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      mark_r  <= 1'b0;
      itime_r <= '0;
      atime_r <= '0;
    end else if (sel) begin
      if (cmd.install) begin
        valid_r <= 1'b1;
        mark_r  <= 1'b0;
        itime_r <= cmd.now;
        atime_r <= cmd.now;
      end else if (cmd.touch) begin
        mark_r  <= 1'b1;
        atime_r <= cmd.now;
      end else if (cmd.clr_mark) begin
        mark_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sel && cmd.install) begin
      page_r <= cmd.page;
      proc_r <= cmd.proc;
    end
  end

  assign info.valid = valid_r;
  assign info.mark  = mark_r;
  assign info.match = valid_r && (page_r == cmd.page) && (proc_r == cmd.proc);
  assign info.page  = page_r;
  assign info.proc  = proc_r;
  assign info.itime = itime_r;
  assign info.atime = atime_r;
endmodule

### hw/rtl/ptr_stage.sv
// One registered link of the oldest-entry chain: compares its cell's time with
// the running minimum and passes the result on. Depends on ptr_pkg.
module ptr_stage import ptr_pkg::*; (
  input  logic              clk,
  input  logic [IDX_W-1:0]  my_idx,
  input  logic [TIME_W-1:0] t,
  input  scan_t             din,
  output scan_t             dout
);
  scan_t nxt;

  always_comb begin
    nxt = din;
    if (t < din.best) begin
      nxt.best = t;
      nxt.idx  = my_idx;
    end
  end

  always_ff @(posedge clk) begin
    dout <= nxt;
  end
endmodule

### hw/rtl/ptr_checker.sv
// Port-level checker for page_table_replacement, bound to the top level.
// Depends on ptr_pkg.
module ptr_checker import ptr_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");
  a_hit_noevict: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> !out_tdata[5])
    else $error("hit reported with an eviction");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second beat accepted while busy");
  a_miss_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[93:62] != 32'd0)
    else $error("miss reported with a zero miss total");
endmodule

bind page_table_replacement ptr_checker u_ptr_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
